FILE: design/lzf_pkg.sv
// Shared types and constants for the LZF stream decompressor.
`default_nettype none
package lzf_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 8192;
    localparam int unsigned LANE_BYTES_DEF   = 8;
    localparam int unsigned DIST_W           = 14;
    localparam int unsigned CNT_W            = 10;
    localparam int unsigned SIZE_W           = 32;
    localparam int unsigned OUT_W            = 64;
    localparam int unsigned FILL_W           = 4;

    // One decoded token handed from the parser to the copy engine.
    typedef struct packed {
        logic              is_match;
        logic              clear;
        logic [7:0]        lit;
        logic [DIST_W-1:0] back_off;
        logic [CNT_W-1:0]  cnt;
        logic              bad;
    } t_cmd;

endpackage
`default_nettype wire

FILE: design/lzf_front.sv
// Token parser: takes compressed bytes, tracks the output budget, issues commands.
`default_nettype none
module lzf_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lzf_pkg::SIZE_W-1:0]    i_output_size,
    input  wire logic                          i_valid,
    input  wire logic [7:0]                    i_in_byte,
    input  wire logic                          i_stream_start,
    output lzf_pkg::t_cmd                      o_cmd,
    output logic                               o_cmd_push
);

    localparam logic [1:0] PH_CONTROL  = 2'd0;
    localparam logic [1:0] PH_LITERAL  = 2'd1;
    localparam logic [1:0] PH_EXTEND   = 2'd2;
    localparam logic [1:0] PH_DISTANCE = 2'd3;

    logic [1:0]                   r_phase, n_phase;
    logic [5:0]                   r_left, n_left;
    logic [8:0]                   r_mlen, n_mlen;
    logic [4:0]                   r_dh, n_dh;
    logic [lzf_pkg::SIZE_W-1:0]   r_prod, n_prod;
    logic                         r_pclear, n_pclear;

    logic [1:0]                   e_phase;
    logic [lzf_pkg::SIZE_W-1:0]   e_prod;
    logic [lzf_pkg::SIZE_W-1:0]   rem;
    logic [lzf_pkg::DIST_W-1:0]   back_off;
    logic [lzf_pkg::CNT_W-1:0]    count;
    logic [lzf_pkg::CNT_W-1:0]    cnt;

    always_comb begin
        e_phase  = i_stream_start ? PH_CONTROL : r_phase;
        e_prod   = i_stream_start ? '0 : r_prod;
        rem      = i_output_size - e_prod;
        back_off = lzf_pkg::DIST_W'({r_dh, i_in_byte}) + lzf_pkg::DIST_W'(1);
        count    = lzf_pkg::CNT_W'(r_mlen) + lzf_pkg::CNT_W'(2);
        cnt      = (rem < lzf_pkg::SIZE_W'(count)) ? rem[lzf_pkg::CNT_W-1:0] : count;

        n_phase  = r_phase;
        n_left   = r_left;
        n_mlen   = r_mlen;
        n_dh     = r_dh;
        n_prod   = r_prod;
        n_pclear = r_pclear;
        o_cmd_push        = 1'b0;
        o_cmd.is_match    = 1'b0;
        o_cmd.clear       = r_pclear || i_stream_start;
        o_cmd.lit         = i_in_byte;
        o_cmd.back_off    = back_off;
        o_cmd.cnt         = cnt;
        o_cmd.bad         = lzf_pkg::SIZE_W'(back_off) > e_prod;

        if (i_valid) begin
            if (i_stream_start) begin
                n_phase  = PH_CONTROL;
                n_prod   = '0;
                n_pclear = 1'b1;
            end
            // finished stream: byte is dropped
            if (e_prod < i_output_size) begin
                case (e_phase)
                    PH_CONTROL: begin
                        if (i_in_byte < 8'h20) begin
                            n_left  = 6'(i_in_byte) + 6'd1;
                            n_phase = PH_LITERAL;
                        end else begin
                            n_mlen  = 9'(i_in_byte[7:5]);
                            n_dh    = i_in_byte[4:0];
                            n_phase = (i_in_byte[7:5] == 3'd7) ? PH_EXTEND : PH_DISTANCE;
                        end
                    end
                    PH_LITERAL: begin
                        o_cmd_push = 1'b1;
                        n_pclear   = 1'b0;
                        n_prod     = e_prod + lzf_pkg::SIZE_W'(1);
                        n_left     = r_left - 6'd1;
                        if (r_left == 6'd1) begin
                            n_phase = PH_CONTROL;
                        end
                    end
                    PH_EXTEND: begin
                        n_mlen  = r_mlen + 9'(i_in_byte);
                        n_phase = PH_DISTANCE;
                    end
                    default: begin
                        o_cmd_push     = 1'b1;
                        o_cmd.is_match = 1'b1;
                        n_pclear       = 1'b0;
                        n_prod         = e_prod + lzf_pkg::SIZE_W'(cnt);
                        n_phase        = PH_CONTROL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CONTROL;
            r_left   <= '0;
            r_mlen   <= '0;
            r_dh     <= '0;
            r_prod   <= '0;
            r_pclear <= 1'b1;
        end else begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_mlen   <= n_mlen;
            r_dh     <= n_dh;
            r_prod   <= n_prod;
            r_pclear <= n_pclear;
        end
    end

endmodule
`default_nettype wire

FILE: design/lzf_cmd_fifo.sv
// Small command queue between the parser and the copy engine.
`default_nettype none
module lzf_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  lzf_pkg::t_cmd      i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output lzf_pkg::t_cmd      o_cmd,
    output logic               o_valid
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned AW    = $clog2(DEPTH);

    lzf_pkg::t_cmd   r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule
`default_nettype wire

FILE: design/lzf_back.sv
// Copy engine: history memory, byte copy loop and result packing.
`default_nettype none
module lzf_back #(
    parameter int unsigned WINDOW_DEPTH = lzf_pkg::WINDOW_DEPTH_DEF,
    parameter int unsigned LANE_BYTES   = lzf_pkg::LANE_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lzf_pkg::SIZE_W-1:0]    i_output_size,
    input  lzf_pkg::t_cmd                      i_cmd,
    input  wire logic                          i_cmd_valid,
    output logic                               o_cmd_pop,
    input  wire logic                          i_res_pop,
    output logic                               o_res_valid,
    output logic [lzf_pkg::OUT_W-1:0]          o_out_bytes,
    output logic [lzf_pkg::FILL_W-1:0]         o_byte_count,
    output logic                               o_last_of_run,
    output logic                               o_stream_done,
    output logic                               o_bad_distance
);

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);

    logic [7:0]                  r_hist [WINDOW_DEPTH];
    logic [7:0]                  r_rd_d;
    logic                        r_fwd;
    logic [7:0]                  r_fwd_d;

    lzf_pkg::t_cmd               r_cmd;
    logic                        r_busy;
    logic [lzf_pkg::CNT_W-1:0]   r_left;
    logic                        r_rd_valid;
    logic                        r_zero_q;
    logic                        r_last_q;
    logic [AW-1:0]               r_wp;
    logic [lzf_pkg::SIZE_W-1:0]  r_prod;
    logic [lzf_pkg::OUT_W-1:0]   r_lane;
    logic [lzf_pkg::FILL_W-1:0]  r_fill;
    logic                        r_out_valid;
    logic [lzf_pkg::OUT_W-1:0]   r_res_bytes;
    logic [lzf_pkg::FILL_W-1:0]  r_res_cnt;
    logic                        r_res_last, r_res_done, r_res_bad;

    logic                        can_go, take, take_lit, take_match;
    logic [AW-1:0]               b_wp, n_wp;
    logic [lzf_pkg::SIZE_W-1:0]  b_prod, n_prod;
    logic                        we, issue, emit, last;
    logic [7:0]                  wbyte;
    logic [AW:0]                 wp_ext, dist_ext;
    logic [AW-1:0]               rd_addr;
    logic                        zero;
    logic [lzf_pkg::OUT_W-1:0]   n_lane;
    logic [lzf_pkg::FILL_W-1:0]  n_fill;

    assign can_go     = !r_out_valid || i_res_pop;
    assign take       = can_go && i_cmd_valid && !r_busy && !r_rd_valid;
    assign take_lit   = take && !i_cmd.is_match;
    assign take_match = take && i_cmd.is_match;
    assign o_cmd_pop  = take;

    always_comb begin
        b_wp    = (take && i_cmd.clear) ? '0 : r_wp;
        b_prod  = (take && i_cmd.clear) ? '0 : r_prod;
        we      = can_go && (r_rd_valid || take_lit);
        wbyte   = take_lit ? i_cmd.lit :
                  (r_zero_q ? 8'd0 : (r_fwd ? r_fwd_d : r_rd_d));
        last    = take_lit || r_last_q;
        n_wp    = b_wp;
        if (we) begin
            n_wp = (b_wp == AW'(WINDOW_DEPTH - 1)) ? '0 : b_wp + AW'(1);
        end
        n_prod  = b_prod + lzf_pkg::SIZE_W'(we);

        issue    = can_go && r_busy;
        wp_ext   = (AW+1)'(n_wp);
        dist_ext = (AW+1)'(r_cmd.back_off);
        if (wp_ext >= dist_ext) begin
            rd_addr = AW'(wp_ext - dist_ext);
        end else begin
            rd_addr = AW'(wp_ext + (AW+1)'(WINDOW_DEPTH) - dist_ext);
        end
        // source before stream start reads as zero
        zero = n_prod < lzf_pkg::SIZE_W'(r_cmd.back_off);

        n_lane = take_lit ? '0 : r_lane;
        n_fill = take_lit ? '0 : r_fill;
        for (int j = 0; j < LANE_BYTES; j++) begin
            if (n_fill == lzf_pkg::FILL_W'(j)) begin
                n_lane[j*8 +: 8] = wbyte;
            end
        end
        n_fill = n_fill + lzf_pkg::FILL_W'(1);
        emit   = we && ((n_fill == lzf_pkg::FILL_W'(LANE_BYTES)) || last);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_hist[b_wp] <= wbyte;
        end
        if (issue) begin
            r_rd_d  <= r_hist[rd_addr];
            r_fwd   <= we && (rd_addr == b_wp);
            r_fwd_d <= wbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_match) begin
            r_cmd <= i_cmd;
        end
        if (issue) begin
            r_zero_q <= zero;
            r_last_q <= (r_left == lzf_pkg::CNT_W'(1));
        end
        if (emit) begin
            r_res_bytes <= n_lane;
            r_res_cnt   <= n_fill;
            r_res_last  <= last;
            r_res_done  <= (n_prod == i_output_size);
            r_res_bad   <= take_lit ? 1'b0 : r_cmd.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_left      <= '0;
            r_rd_valid  <= 1'b0;
            r_wp        <= '0;
            r_prod      <= '0;
            r_lane      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (can_go) begin
                r_wp       <= n_wp;
                r_prod     <= n_prod;
                r_rd_valid <= issue;
                if (we) begin
                    r_lane <= emit ? '0 : n_lane;
                    r_fill <= emit ? '0 : n_fill;
                end
            end
            if (take_match) begin
                r_busy <= 1'b1;
                r_left <= i_cmd.cnt;
            end else if (issue) begin
                r_left <= r_left - lzf_pkg::CNT_W'(1);
                if (r_left == lzf_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_out_bytes    = r_res_bytes;
    assign o_byte_count   = r_res_cnt;
    assign o_last_of_run  = r_res_last;
    assign o_stream_done  = r_res_done;
    assign o_bad_distance = r_res_bad;

endmodule
`default_nettype wire

FILE: design/lzf_stream_decompressor.sv
// Top level of the LZF stream decompressor.
// Compressed bytes enter through push/full, one per beat; decoded bytes leave through
// empty/pop in results of up to LANE_BYTES bytes. Control, extension and literal bytes
// are taken one per cycle while the four-entry command queue has room. A back reference
// copies one byte per cycle through the history memory (one read and one write port),
// and the copy engine takes no new command until a match's last byte is written;
// a literal is written as its command is taken. A result that is not popped
// stalls the copy engine, and a full command queue stalls input. No clearing pass runs
// after reset. Write output_size only while the block is idle.
`default_nettype none
module lzf_stream_decompressor #(
    parameter int unsigned WINDOW_DEPTH = lzf_pkg::WINDOW_DEPTH_DEF,
    parameter int unsigned LANE_BYTES   = lzf_pkg::LANE_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    i_in_byte,
    input  wire logic                          i_stream_start,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [lzf_pkg::OUT_W-1:0]          o_out_bytes,
    output logic [lzf_pkg::FILL_W-1:0]         o_byte_count,
    output logic                               o_last_of_run,
    output logic                               o_stream_done,
    output logic                               o_bad_distance,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lzf_pkg::SIZE_W-1:0]    i_cfg_output_size
);

    logic [lzf_pkg::SIZE_W-1:0] r_out_size;
    lzf_pkg::t_cmd              f_cmd, q_cmd;
    logic                       f_push, q_valid, q_pop, res_valid, in_take;

    assign o_cfg_ready = 1'b1;
    assign in_take     = push && !full;
    assign empty       = !res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_size <= '0;
        end else if (i_cfg_valid) begin
            r_out_size <= i_cfg_output_size;
        end
    end

    lzf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_output_size  (r_out_size),
        .i_valid        (in_take),
        .i_in_byte      (i_in_byte),
        .i_stream_start (i_stream_start),
        .o_cmd          (f_cmd),
        .o_cmd_push     (f_push)
    );

    lzf_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_valid (q_valid)
    );

    lzf_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .LANE_BYTES   (LANE_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_output_size  (r_out_size),
        .i_cmd          (q_cmd),
        .i_cmd_valid    (q_valid),
        .o_cmd_pop      (q_pop),
        .i_res_pop      (pop),
        .o_res_valid    (res_valid),
        .o_out_bytes    (o_out_bytes),
        .o_byte_count   (o_byte_count),
        .o_last_of_run  (o_last_of_run),
        .o_stream_done  (o_stream_done),
        .o_bad_distance (o_bad_distance)
    );

endmodule
`default_nettype wire
